// File: hdl/sm64_pkg.sv
// ----------------------------------------------------------------------------
// SplitMix64 shared definitions
// Constants and widths used by the generator and its serial arithmetic units.
// ----------------------------------------------------------------------------
package sm64_pkg;

    localparam int WORD_W = 64;

    localparam logic [WORD_W-1:0] GOLDEN_STEP = 64'h9E37_79B9_7F4A_7C15;
    localparam logic [WORD_W-1:0] MIX_MUL_A   = 64'hBF58_476D_1CE4_E5B9;
    localparam logic [WORD_W-1:0] MIX_MUL_B   = 64'h94D0_49BB_1331_11EB;

    localparam int SHIFT_A    = 30;
    localparam int SHIFT_B    = 27;
    localparam int SHIFT_C    = 31;
    localparam int FRAC_SHIFT = 12;

    // Double layout.
    localparam int FRAC_W = WORD_W - FRAC_SHIFT;
    localparam int EXP_W  = 11;
    // Biased exponent when the leading one already sits at the top of the fraction.
    localparam logic [EXP_W-1:0] EXP_TOP = 11'd1022;

    // Constant multiplier: one digit of the constant per cycle.
    localparam int MUL_DIGIT = 4;
    localparam int MUL_STEPS = WORD_W / MUL_DIGIT;
    localparam int MUL_CNT_W = $clog2(MUL_STEPS);

    localparam int DIV_CNT_W  = $clog2(WORD_W);
    localparam int NORM_CNT_W = $clog2(FRAC_W);

    typedef logic [WORD_W-1:0] word_t;

endpackage

// File: hdl/sm64_cmul.sv
// ----------------------------------------------------------------------------
// SplitMix64 digit-serial multiplier
// Low word of x times c, one radix-16 digit of c per cycle.
// ----------------------------------------------------------------------------
module sm64_cmul
    import sm64_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  start,
    input  word_t x,
    input  word_t c,
    output logic  done,
    output word_t product
);

    word_t                mcand_reg, mcand_next;
    word_t                mult_reg, mult_next;
    word_t                acc_reg, acc_next;
    logic [MUL_CNT_W-1:0] cnt_reg, cnt_next;
    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;

    always_comb
    begin
        mcand_next = mcand_reg;
        mult_next  = mult_reg;
        acc_next   = acc_reg;
        cnt_next   = cnt_reg;
        busy_next  = busy_reg;
        done_next  = 1'b0;
        if (start)
        begin
            mcand_next = x;
            mult_next  = c;
            acc_next   = '0;
            cnt_next   = '0;
            busy_next  = 1'b1;
        end
        else if (busy_reg)
        begin
            acc_next   = acc_reg + (mcand_reg * WORD_W'(mult_reg[MUL_DIGIT-1:0]));
            mcand_next = mcand_reg << MUL_DIGIT;
            mult_next  = mult_reg >> MUL_DIGIT;
            cnt_next   = cnt_reg + 1'b1;
            if (cnt_reg == MUL_CNT_W'(MUL_STEPS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mcand_reg <= mcand_next;
        mult_reg  <= mult_next;
        acc_reg   <= acc_next;
    end

    assign done    = done_reg;
    assign product = acc_reg;

endmodule

// File: hdl/sm64_divu.sv
// ----------------------------------------------------------------------------
// SplitMix64 serial remainder
// Restoring division, one dividend bit per cycle; only the remainder is kept.
// ----------------------------------------------------------------------------
module sm64_divu
    import sm64_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  start,
    input  word_t dividend,
    input  word_t divisor,
    output logic  done,
    output word_t remainder
);

    word_t                dvd_reg, dvd_next;
    word_t                dsr_reg, dsr_next;
    word_t                rem_reg, rem_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [WORD_W:0]      trial;
    logic [WORD_W:0]      diff;

    always_comb
    begin
        trial      = {rem_reg, dvd_reg[WORD_W-1]};
        diff       = trial - {1'b0, dsr_reg};
        dvd_next   = dvd_reg;
        dsr_next   = dsr_reg;
        rem_next   = rem_reg;
        cnt_next   = cnt_reg;
        busy_next  = busy_reg;
        done_next  = 1'b0;
        if (start)
        begin
            dvd_next  = dividend;
            dsr_next  = divisor;
            rem_next  = '0;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            // The remainder stays below the divisor, so the difference fits a word.
            if (!diff[WORD_W])
                rem_next = diff[WORD_W-1:0];
            else
                rem_next = trial[WORD_W-1:0];
            dvd_next = dvd_reg << 1;
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == DIV_CNT_W'(WORD_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        dsr_reg <= dsr_next;
        rem_reg <= rem_next;
    end

    assign done      = done_reg;
    assign remainder = rem_reg;

endmodule

// File: hdl/sm64_norm.sv
// ----------------------------------------------------------------------------
// SplitMix64 fraction normalizer
// Shifts the 52-bit fraction left one bit per cycle and forms double bits.
// ----------------------------------------------------------------------------
module sm64_norm
    import sm64_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [FRAC_W-1:0] fraction,
    output logic              done,
    output word_t             unit_bits
);

    logic [FRAC_W-1:0]     man_reg, man_next;
    logic [NORM_CNT_W-1:0] shift_reg, shift_next;
    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [EXP_W-1:0]      exponent;

    always_comb
    begin
        man_next   = man_reg;
        shift_next = shift_reg;
        busy_next  = busy_reg;
        done_next  = 1'b0;
        if (start)
        begin
            man_next   = fraction;
            shift_next = '0;
            busy_next  = 1'b1;
        end
        else if (busy_reg)
        begin
            if (man_reg[FRAC_W-1] || (man_reg == '0))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                man_next   = man_reg << 1;
                shift_next = shift_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        man_reg   <= man_next;
        shift_reg <= shift_next;
    end

    // The leading one becomes the hidden bit; the rest is the stored fraction.
    assign exponent  = EXP_TOP - EXP_W'(shift_reg);
    assign unit_bits = (man_reg == '0) ? '0
                                       : {1'b0, exponent, man_reg[FRAC_W-2:0], 1'b0};
    assign done      = done_reg;

endmodule

// File: hdl/splitmix64_random_generator.sv
// ----------------------------------------------------------------------------
// SplitMix64 random generator
// Each beat gives one 64-bit draw as raw, ranged and unit-interval views.
// ----------------------------------------------------------------------------
// Once an input beat is accepted, the draw goes through two 16-step digit-serial
// multiplies for the mixing function, then a 64-step serial remainder for the
// ranged view, with the fraction normalizer running alongside it. One item is
// worked on at a time; in_stall stays high until the result is loaded, so a new
// item is not taken before then. A finished result may wait in the output
// register as the next item is taken. Writing seed_value loads the running
// state directly; write it only while the block is idle.
module splitmix64_random_generator
    import sm64_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               seed_we,
    input  logic [63:0]        seed_value,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic signed [63:0] range_low,
    input  logic signed [63:0] range_high,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [63:0]        raw_value,
    output logic signed [63:0] ranged_value,
    output logic [63:0]        unit_bits
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL_A,
        ST_MUL_B,
        ST_TAIL,
        ST_HOLD
    } fsm_t;

    fsm_t  fsm_reg;
    word_t run_reg;
    word_t lo_reg;
    word_t span_reg;
    word_t draw_reg;
    logic  div_flag_reg;
    logic  norm_flag_reg;
    logic  out_valid_reg;
    word_t raw_reg;
    word_t ranged_reg;
    word_t unit_reg;

    logic  in_accept;
    logic  out_free;
    word_t lo_sel;
    word_t hi_sel;
    word_t new_state;
    word_t mul_x;
    word_t mul_c;
    logic  mul_start;
    logic  mul_done;
    word_t mul_prod;
    word_t draw_w;
    logic  tail_start;
    logic  div_done;
    word_t div_rem;
    logic  norm_done;
    word_t norm_bits;
    logic  tail_ready;
    word_t ranged_w;

    assign in_accept = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;

    always_comb
    begin
        if ($signed(range_high) < $signed(range_low))
        begin
            lo_sel = range_high;
            hi_sel = range_low;
        end
        else
        begin
            lo_sel = range_low;
            hi_sel = range_high;
        end
        new_state = run_reg + GOLDEN_STEP;
        if (fsm_reg == ST_IDLE)
        begin
            mul_x = new_state ^ (new_state >> SHIFT_A);
            mul_c = MIX_MUL_A;
        end
        else
        begin
            mul_x = mul_prod ^ (mul_prod >> SHIFT_B);
            mul_c = MIX_MUL_B;
        end
        mul_start  = in_accept || ((fsm_reg == ST_MUL_A) && mul_done);
        draw_w     = mul_prod ^ (mul_prod >> SHIFT_C);
        tail_start = (fsm_reg == ST_MUL_B) && mul_done;
        tail_ready = (div_flag_reg || div_done) && (norm_flag_reg || norm_done);
        ranged_w   = (span_reg == '0) ? lo_reg : (lo_reg + div_rem);
    end

    sm64_cmul u_cmul (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_start),
        .x       (mul_x),
        .c       (mul_c),
        .done    (mul_done),
        .product (mul_prod)
    );

    sm64_divu u_divu (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (tail_start),
        .dividend  (draw_w),
        .divisor   (span_reg),
        .done      (div_done),
        .remainder (div_rem)
    );

    sm64_norm u_norm (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (tail_start),
        .fraction  (draw_w[WORD_W-1:FRAC_SHIFT]),
        .done      (norm_done),
        .unit_bits (norm_bits)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fsm_reg       <= ST_IDLE;
            run_reg       <= '0;
            lo_reg        <= '0;
            span_reg      <= '0;
            draw_reg      <= '0;
            div_flag_reg  <= 1'b0;
            norm_flag_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            raw_reg       <= '0;
            ranged_reg    <= '0;
            unit_reg      <= '0;
        end
        else
        begin
            if ((fsm_reg == ST_HOLD) && out_free)
                out_valid_reg <= 1'b1;
            else if (out_valid_reg && !out_stall)
                out_valid_reg <= 1'b0;
            // An input beat is taken only in the idle state.
            if (seed_we)
                run_reg <= seed_value;
            else if (in_accept)
                run_reg <= new_state;
            case (fsm_reg)
                ST_IDLE:
                begin
                    if (in_accept)
                    begin
                        lo_reg   <= lo_sel;
                        span_reg <= hi_sel - lo_sel;
                        fsm_reg  <= ST_MUL_A;
                    end
                end
                ST_MUL_A:
                begin
                    if (mul_done)
                        fsm_reg <= ST_MUL_B;
                end
                ST_MUL_B:
                begin
                    if (mul_done)
                    begin
                        draw_reg      <= draw_w;
                        div_flag_reg  <= 1'b0;
                        norm_flag_reg <= 1'b0;
                        fsm_reg       <= ST_TAIL;
                    end
                end
                ST_TAIL:
                begin
                    if (div_done)
                        div_flag_reg <= 1'b1;
                    if (norm_done)
                        norm_flag_reg <= 1'b1;
                    if (tail_ready)
                        fsm_reg <= ST_HOLD;
                end
                ST_HOLD:
                begin
                    if (out_free)
                    begin
                        raw_reg    <= draw_reg;
                        ranged_reg <= ranged_w;
                        unit_reg   <= norm_bits;
                        fsm_reg    <= ST_IDLE;
                    end
                end
                default:
                begin
                    fsm_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign in_stall     = (fsm_reg != ST_IDLE);
    assign out_valid    = out_valid_reg;
    assign raw_value    = raw_reg;
    assign ranged_value = ranged_reg;
    assign unit_bits    = unit_reg;

    // Once an item is taken, no further beat is accepted until its result is loaded.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> in_stall)
        else $error("input accepted while an item was in flight");

    // A new result appears only out of the hold state.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(fsm_reg == ST_HOLD))
        else $error("result loaded outside the hold state");

    // A nonzero unit value is a positive double below one.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (unit_bits != '0)) |->
            (!unit_bits[63] && (unit_bits[62:52] < 11'h3FF)))
        else $error("unit value outside [0,1)");

    // The multiplier finishes only while the sequencer waits for it.
    assert property (@(posedge clk) disable iff (!rst_n)
        mul_done |-> ((fsm_reg == ST_MUL_A) || (fsm_reg == ST_MUL_B)))
        else $error("multiplier finished outside a multiply step");

endmodule

// File: dv/tb.sv
// ----------------------------------------------------------------------------
// SplitMix64 random generator testbench
// A short table of bound pairs and seeds, then random bounds over three idle
// patterns. Every output beat is checked field by field against an in-bench
// model of the generator state, the mixing function and the two derived views.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import sm64_pkg::word_t;

    localparam word_t GOLDEN = 64'h9E37_79B9_7F4A_7C15;
    localparam word_t MUL_A  = 64'hBF58_476D_1CE4_E5B9;
    localparam word_t MUL_B  = 64'h94D0_49BB_1331_11EB;
    localparam word_t FRAC_MASK = 64'h000F_FFFF_FFFF_FFFF;

    localparam word_t S_MIN = 64'h8000_0000_0000_0000;
    localparam word_t S_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam word_t ALL1  = 64'hFFFF_FFFF_FFFF_FFFF;

    localparam bit [2:0] K_NONE   = 3'b000;
    localparam bit [2:0] K_RAW    = 3'b001;
    localparam bit [2:0] K_RANGED = 3'b010;
    localparam bit [2:0] K_UNIT   = 3'b100;
    localparam bit [2:0] K_ALL    = 3'b111;

    localparam int RANDOM_PER_PHASE = 600;

    typedef struct packed {
        word_t raw;
        word_t ranged;
        word_t unit;
    } draw_views_t;

    // KEEP sends as is, LOAD writes the seed, AIM writes the seed that makes
    // the next draw equal to the given value.
    typedef enum logic [1:0] {SEED_KEEP, SEED_LOAD, SEED_AIM} seed_op_t;

    typedef struct packed {
        seed_op_t    op;
        word_t       arg;
        word_t       lo;
        word_t       hi;
        bit [2:0]    known;
        draw_views_t typed;
    } stim_row_t;

    localparam stim_row_t DIRECTED [20] = '{
        // first draw after reset, zero range at zero
        '{SEED_KEEP, 64'd0, 64'd0, 64'd0, K_RANGED, '{64'd0, 64'd0, 64'd0}},
        '{SEED_KEEP, 64'd0, S_MIN, S_MAX, K_NONE, '{64'd0, 64'd0, 64'd0}},
        '{SEED_KEEP, 64'd0, S_MAX, S_MIN, K_NONE, '{64'd0, 64'd0, 64'd0}},
        '{SEED_KEEP, 64'd0, S_MAX, S_MAX, K_RANGED, '{64'd0, S_MAX, 64'd0}},
        '{SEED_KEEP, 64'd0, S_MIN, S_MIN, K_RANGED, '{64'd0, S_MIN, 64'd0}},
        '{SEED_KEEP, 64'd0, ALL1, 64'd0, K_RANGED, '{64'd0, ALL1, 64'd0}},
        '{SEED_KEEP, 64'd0, 64'd5, 64'hFFFF_FFFF_FFFF_FFFB, K_NONE,
          '{64'd0, 64'd0, 64'd0}},
        '{SEED_KEEP, 64'd0, 64'd0, S_MAX, K_NONE, '{64'd0, 64'd0, 64'd0}},
        '{SEED_KEEP, 64'd0, S_MIN, 64'd0, K_NONE, '{64'd0, 64'd0, 64'd0}},
        // reversed bounds of width one
        '{SEED_KEEP, 64'd0, 64'd0, ALL1, K_RANGED, '{64'd0, ALL1, 64'd0}},
        '{SEED_LOAD, ALL1, 64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA, K_NONE,
          '{64'd0, 64'd0, 64'd0}},
        '{SEED_KEEP, 64'd0, 64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555, K_NONE,
          '{64'd0, 64'd0, 64'd0}},
        // zero draw: zero fraction and the lower bound
        '{SEED_AIM, 64'd0, 64'hFFFF_FFFF_FFFF_FFF9, 64'd100, K_ALL,
          '{64'd0, 64'hFFFF_FFFF_FFFF_FFF9, 64'd0}},
        '{SEED_AIM, ALL1, 64'd0, 64'd1, K_ALL,
          '{ALL1, 64'd0, 64'h3FEF_FFFF_FFFF_FFFE}},
        '{SEED_AIM, 64'h1000, 64'd10, 64'd10, K_ALL,
          '{64'h1000, 64'd10, 64'h3CB0_0000_0000_0000}},
        // fraction bits all zero but low bits set
        '{SEED_AIM, 64'hFFF, S_MIN, S_MAX, K_RAW | K_UNIT,
          '{64'hFFF, 64'd0, 64'd0}},
        '{SEED_AIM, S_MIN, 64'd0, 64'd0, K_ALL,
          '{S_MIN, 64'd0, 64'h3FE0_0000_0000_0000}},
        '{SEED_KEEP, 64'd0, ALL1, ALL1, K_RANGED, '{64'd0, ALL1, 64'd0}},
        '{SEED_LOAD, 64'h0123_4567_89AB_CDEF, 64'd1, 64'd2, K_RANGED,
          '{64'd0, 64'd1, 64'd0}},
        '{SEED_KEEP, 64'd0, 64'd2, 64'd1, K_RANGED, '{64'd0, 64'd1, 64'd0}}
    };

    logic               clk;
    logic               rst_n        = 1'b0;
    logic               seed_we      = 1'b0;
    logic [63:0]        seed_value   = '0;
    logic               in_valid     = 1'b0;
    logic               in_stall;
    logic signed [63:0] range_low    = '0;
    logic signed [63:0] range_high   = '0;
    logic               out_valid;
    logic               out_stall    = 1'b0;
    logic [63:0]        raw_value;
    logic signed [63:0] ranged_value;
    logic [63:0]        unit_bits;

    word_t       gen_state = '0;
    draw_views_t pending_draws [$];
    int          fail_count  = 0;
    int          tx_idle_pct = 0;
    int          rx_idle_pct = 0;
    int          stall_hold  = 0;

    splitmix64_random_generator u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .seed_we      (seed_we),
        .seed_value   (seed_value),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .range_low    (range_low),
        .range_high   (range_high),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .raw_value    (raw_value),
        .ranged_value (ranged_value),
        .unit_bits    (unit_bits)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #50_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    function automatic word_t mix64(word_t s);
        word_t z;
        z = (s ^ (s >> 30)) * MUL_A;
        z = (z ^ (z >> 27)) * MUL_B;
        return z ^ (z >> 31);
    endfunction

    function automatic word_t undo_xorshift(word_t y, int sh);
        word_t x;
        x = y;
        // Every pass recovers another sh bits from the top down.
        repeat (3) x = y ^ (x >> sh);
        return x;
    endfunction

    function automatic word_t mul_inverse(word_t a);
        word_t x;
        x = a;
        // Newton steps double the number of correct low bits each time.
        repeat (6) x = x * (64'd2 - a * x);
        return x;
    endfunction

    function automatic word_t unmix64(word_t d);
        word_t z;
        z = undo_xorshift(d, 31) * mul_inverse(MUL_B);
        z = undo_xorshift(z, 27) * mul_inverse(MUL_A);
        return undo_xorshift(z, 30);
    endfunction

    function automatic word_t unit_view(word_t d);
        word_t m;
        word_t expo;
        int    top;
        m = d >> 12;
        top = 0;
        if (m == '0)
            return '0;
        for (int i = 0; i < 52; i++)
            if (m[i])
                top = i;
        expo = word_t'(top + 971);
        return (expo << 52) | ((m << (52 - top)) & FRAC_MASK);
    endfunction

    function automatic draw_views_t next_views(word_t lo, word_t hi);
        draw_views_t v;
        word_t       a;
        word_t       b;
        word_t       span;
        word_t       d;
        a = lo;
        b = hi;
        if ($signed(b) < $signed(a))
        begin
            a = hi;
            b = lo;
        end
        span = b - a;
        gen_state = gen_state + GOLDEN;
        d = mix64(gen_state);
        v.raw = d;
        v.ranged = (span == '0) ? a : a + d % span;
        v.unit = unit_view(d);
        return v;
    endfunction

    function automatic word_t rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic word_t extreme_bound();
        case ($urandom_range(4))
            0: return S_MIN;
            1: return S_MAX;
            2: return '0;
            3: return ALL1;
            default: return 64'd1;
        endcase
    endfunction

    // Leaves in_valid high after the accepting edge, so back-to-back beats
    // never lower and raise it in the same step.
    task automatic send_range(input word_t lo, input word_t hi, input bit [2:0] known,
                              input draw_views_t typed);
        draw_views_t want;
        if (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(15) == 0 ? $urandom_range(120, 20) : $urandom_range(6, 1))
                @(posedge clk);
        end
        in_valid   <= 1'b1;
        range_low  <= lo;
        range_high <= hi;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        want = next_views(lo, hi);
        if (known[0])
            want.raw = typed.raw;
        if (known[1])
            want.ranged = typed.ranged;
        if (known[2])
            want.unit = typed.unit;
        pending_draws.push_back(want);
    endtask

    task automatic load_seed(input word_t v);
        in_valid <= 1'b0;
        while (pending_draws.size() != 0)
            @(posedge clk);
        seed_we    <= 1'b1;
        seed_value <= v;
        @(posedge clk);
        seed_we   <= 1'b0;
        gen_state = v;
    endtask

    task automatic random_ranges(input int n);
        word_t lo;
        word_t hi;
        for (int k = 0; k < n; k++)
        begin
            lo = rand64();
            hi = rand64();
            case ($urandom_range(9))
                0, 1, 2, 3: ;
                4: hi = lo + word_t'($urandom_range(1000, 1));
                5: hi = lo;
                6:
                begin
                    lo = extreme_bound();
                    hi = extreme_bound();
                end
                7:
                begin
                    lo = word_t'($urandom_range(200)) - 64'd100;
                    hi = word_t'($urandom_range(200)) - 64'd100;
                end
                8: lo = extreme_bound();
                default: lo = hi + word_t'($urandom_range(1000, 1));
            endcase
            send_range(lo, hi, K_NONE, '0);
        end
    endtask

    always @(posedge clk)
    begin
        draw_views_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_draws.size() == 0)
            begin
                $error("unexpected result beat, raw_value %h", raw_value);
                fail_count++;
            end
            else
            begin
                want = pending_draws.pop_front();
                if (raw_value !== want.raw)
                begin
                    $error("raw_value: expected %h, got %h", want.raw, raw_value);
                    fail_count++;
                end
                if (ranged_value !== $signed(want.ranged))
                begin
                    $error("ranged_value: expected %0d, got %0d", $signed(want.ranged),
                           ranged_value);
                    fail_count++;
                end
                if (unit_bits !== want.unit)
                begin
                    $error("unit_bits: expected %h, got %h", want.unit, unit_bits);
                    fail_count++;
                end
            end
        end
        // Mostly short stalls, now and then a long one so the output beat
        // waits across the whole computation of the next item.
        if (stall_hold != 0)
            stall_hold--;
        else if (rx_idle_pct != 0 && $urandom_range(99) < rx_idle_pct)
            stall_hold = ($urandom_range(15) == 0) ? $urandom_range(150, 20)
                                                   : $urandom_range(6, 1);
        out_stall <= (stall_hold != 0);
    end

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        tx_idle_pct = 37;
        rx_idle_pct = 74;
        foreach (DIRECTED[i])
        begin
            case (DIRECTED[i].op)
                SEED_LOAD: load_seed(DIRECTED[i].arg);
                SEED_AIM:  load_seed(unmix64(DIRECTED[i].arg) - GOLDEN);
                default: ;
            endcase
            send_range(DIRECTED[i].lo, DIRECTED[i].hi, DIRECTED[i].known,
                       DIRECTED[i].typed);
        end
        random_ranges(RANDOM_PER_PHASE);

        load_seed('0);
        tx_idle_pct = 74;
        rx_idle_pct = 37;
        random_ranges(RANDOM_PER_PHASE);

        load_seed(rand64());
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        random_ranges(RANDOM_PER_PHASE);

        in_valid <= 1'b0;
        while (pending_draws.size() != 0)
            @(posedge clk);
        repeat (150) @(posedge clk);
        if (fail_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
